// ===== hw/rtl/kda_pkg.sv =====
package kda_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int CFG_BITS       = 15;
    localparam int BEEP_BITS      = 8;
    localparam int CFG_IDX_BITS   = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_LONG_PRESS   = 3'd1,
        REG_SLOW_REPEAT  = 3'd2,
        REG_SLOW4_DELAY  = 3'd3,
        REG_SLOW4_REPEAT = 3'd4,
        REG_FAST_START   = 3'd5,
        REG_FAST_REPEAT  = 3'd6,
        REG_BEEP         = 3'd7
    } t_reg_idx;

    localparam logic [CFG_BITS-1:0]  DEF_DEBOUNCE     = 15'd12;
    localparam logic [CFG_BITS-1:0]  DEF_LONG_PRESS   = 15'd120;
    localparam logic [CFG_BITS-1:0]  DEF_SLOW_REPEAT  = 15'd80;
    localparam logic [CFG_BITS-1:0]  DEF_SLOW4_DELAY  = 15'd40;
    localparam logic [CFG_BITS-1:0]  DEF_SLOW4_REPEAT = 15'd20;
    localparam logic [CFG_BITS-1:0]  DEF_FAST_START   = 15'd40;
    localparam logic [CFG_BITS-1:0]  DEF_FAST_REPEAT  = 15'd4;
    localparam logic [BEEP_BITS-1:0] DEF_BEEP         = 8'd5;

    localparam int FLAG_SLOW  = 0;
    localparam int FLAG_SLOW4 = 1;
    localparam int FLAG_FAST  = 2;

    typedef struct packed {
        logic [CFG_BITS-1:0]  debounce_ticks;
        logic [CFG_BITS-1:0]  long_press_ticks;
        logic [CFG_BITS-1:0]  slow_repeat_ticks;
        logic [CFG_BITS-1:0]  slow4_delay_ticks;
        logic [CFG_BITS-1:0]  slow4_repeat_ticks;
        logic [CFG_BITS-1:0]  fast_start_ticks;
        logic [CFG_BITS-1:0]  fast_repeat_ticks;
        logic [BEEP_BITS-1:0] beep_ticks;
    } t_cfg;

    typedef struct packed {
        logic       key_down;
        logic [5:0] key_index;
        logic [7:0] key_flags;
        logic [7:0] key_code;
        logic [7:0] key_hold_code;
        logic [7:0] hold_query_mask;
    } t_request;

    typedef struct packed {
        logic       key_valid;
        logic [7:0] key_out;
        logic       enc_valid;
        logic [7:0] enc_code;
        logic       enc_press;
        logic       beep_on;
        logic       hold_match;
    } t_result;

endpackage

// ===== hw/rtl/kda_req_if.sv =====
interface kda_req_if;
    logic       valid;
    logic       ready;
    logic       key_down;
    logic [5:0] key_index;
    logic [7:0] key_flags;
    logic [7:0] key_code;
    logic [7:0] key_hold_code;
    logic [7:0] hold_query_mask;

    modport source (
        output valid, key_down, key_index, key_flags, key_code, key_hold_code,
               hold_query_mask,
        input  ready
    );
    modport sink (
        input  valid, key_down, key_index, key_flags, key_code, key_hold_code,
               hold_query_mask,
        output ready
    );
endinterface

// ===== hw/rtl/kda_rsp_if.sv =====
interface kda_rsp_if;
    logic       valid;
    logic       ready;
    logic       key_valid;
    logic [7:0] key_out;
    logic       enc_valid;
    logic [7:0] enc_code;
    logic       enc_press;
    logic       beep_on;
    logic       hold_match;

    modport source (
        output valid, key_valid, key_out, enc_valid, enc_code, enc_press, beep_on,
               hold_match,
        input  ready
    );
    modport sink (
        input  valid, key_valid, key_out, enc_valid, enc_code, enc_press, beep_on,
               hold_match,
        output ready
    );
endinterface

// ===== hw/rtl/kda_step.sv =====
module kda_step #(
    parameter int COUNT_BITS = kda_pkg::COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  kda_pkg::t_request i_req,
    input  kda_pkg::t_cfg     i_cfg,
    output kda_pkg::t_result  o_res
);

    localparam int CMPW = (COUNT_BITS > kda_pkg::CFG_BITS + 1) ? COUNT_BITS
                                                               : kda_pkg::CFG_BITS + 1;

    logic [COUNT_BITS-1:0]         r_press, n_press;
    logic [COUNT_BITS-1:0]         r_rel, n_rel;
    logic [5:0]                    r_key, n_key;
    logic [7:0]                    r_flags, n_flags;
    logic [7:0]                    r_code, n_code;
    logic [7:0]                    r_hcode, n_hcode;
    logic [kda_pkg::BEEP_BITS-1:0] r_beep, n_beep;

    logic                          notstab;
    logic                          fresh;
    logic [COUNT_BITS-1:0]         inc;
    logic [COUNT_BITS-1:0]         rel_dec;
    logic [kda_pkg::CFG_BITS-1:0]  rep_first;
    logic [kda_pkg::CFG_BITS-1:0]  rep_int;
    logic                          kv, ev, epress;
    logic [7:0]                    kout, ecode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press <= '0;
            r_rel   <= '0;
            r_key   <= '0;
            r_flags <= '0;
            r_code  <= '0;
            r_hcode <= '0;
            r_beep  <= '0;
        end else if (i_accept) begin
            r_press <= n_press;
            r_rel   <= n_rel;
            r_key   <= n_key;
            r_flags <= n_flags;
            r_code  <= n_code;
            r_hcode <= n_hcode;
            r_beep  <= n_beep;
        end
    end

    always_comb begin
        notstab = CMPW'(r_press) < (CMPW'(i_cfg.debounce_ticks) + CMPW'(1));
        inc     = r_press + COUNT_BITS'(1);
        rel_dec = r_rel - COUNT_BITS'(1);
        if (r_flags[kda_pkg::FLAG_SLOW]) begin
            rep_first = i_cfg.long_press_ticks;
            rep_int   = i_cfg.slow_repeat_ticks;
        end else begin
            rep_first = i_cfg.slow4_delay_ticks;
            rep_int   = i_cfg.slow4_repeat_ticks;
        end

        priority if (!notstab && r_key != i_req.key_index) fresh = 1'b1;
        else if (r_rel != '0 && !notstab)                  fresh = 1'b0;
        else if (r_press == '0)                            fresh = 1'b1;
        else if (notstab && r_key != i_req.key_index)      fresh = 1'b1;
        else                                               fresh = 1'b0;

        n_press = r_press;
        n_rel   = r_rel;
        n_key   = r_key;
        n_flags = r_flags;
        n_code  = r_code;
        n_hcode = r_hcode;
        kv      = 1'b0;
        ev      = 1'b0;
        epress  = 1'b0;
        kout    = '0;
        ecode   = '0;

        if (i_req.key_down) begin
            if (fresh) begin
                n_key   = i_req.key_index;
                n_flags = i_req.key_flags;
                n_code  = i_req.key_code;
                n_hcode = i_req.key_hold_code;
                n_press = COUNT_BITS'(1);
                n_rel   = '0;
            end else begin
                n_rel = COUNT_BITS'(i_cfg.debounce_ticks);
                priority if (r_flags[kda_pkg::FLAG_SLOW] || r_flags[kda_pkg::FLAG_SLOW4]) begin
                    n_press = inc;
                    if (CMPW'(inc) == CMPW'(rep_first) + CMPW'(rep_int)) begin
                        n_press = COUNT_BITS'(rep_first);
                        kv      = 1'b1;
                        kout    = r_code;
                        n_rel   = '0;
                    end else if (CMPW'(inc) == CMPW'(rep_first)) begin
                        kv    = 1'b1;
                        kout  = r_code;
                        n_rel = '0;
                    end
                end else if (r_flags[kda_pkg::FLAG_FAST]) begin
                    n_press = inc;
                    if (CMPW'(inc) == CMPW'(i_cfg.fast_start_ticks)) begin
                        n_press = COUNT_BITS'(i_cfg.fast_start_ticks)
                                - COUNT_BITS'(i_cfg.fast_repeat_ticks);
                        ev      = 1'b1;
                        ecode   = r_code;
                        epress  = 1'b1;
                    end
                end else if (CMPW'(r_press) < CMPW'(i_cfg.long_press_ticks)) begin
                    n_press = inc;
                    if (CMPW'(inc) == CMPW'(i_cfg.long_press_ticks)) begin
                        kv   = 1'b1;
                        kout = r_hcode;
                    end
                end
            end
        end else if (r_rel != '0) begin
            if (notstab) begin
                n_press = '0;
                n_rel   = '0;
            end else begin
                n_rel = rel_dec;
                if (rel_dec == '0) begin
                    if (r_flags[kda_pkg::FLAG_FAST]) begin
                        ev    = 1'b1;
                        ecode = r_code;
                    end else if (CMPW'(r_press) < CMPW'(i_cfg.long_press_ticks)) begin
                        kv   = 1'b1;
                        kout = r_code;
                    end
                    n_press = '0;
                end
            end
        end

        if (kv) begin
            n_beep = i_cfg.beep_ticks;
        end else if (r_beep != '0) begin
            n_beep = r_beep - kda_pkg::BEEP_BITS'(1);
        end else begin
            n_beep = r_beep;
        end

        o_res.key_valid  = kv;
        o_res.key_out    = kout;
        o_res.enc_valid  = ev;
        o_res.enc_code   = ecode;
        o_res.enc_press  = epress;
        o_res.beep_on    = n_beep != '0;
        o_res.hold_match = (n_press != '0) && ((n_flags & i_req.hold_query_mask) != '0);
    end

endmodule

// ===== hw/rtl/kda_out_buf.sv =====
module kda_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kda_pkg::t_result i_data,
    output logic             o_space,
    output logic             o_valid,
    input  logic             i_pop_ready,
    output kda_pkg::t_result o_data
);

    logic             r_main_valid, r_skid_valid;
    kda_pkg::t_result r_main, r_skid;
    logic             pop;

    assign pop     = r_main_valid && i_pop_ready;
    assign o_space = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_data  = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                r_main_valid <= 1'b1;
                r_main       <= i_data;
            end else begin
                r_skid_valid <= 1'b1;
                r_skid       <= i_data;
            end
        end else if (pop) begin
            if (r_skid_valid) begin
                r_main       <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_main_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/key_debounce_autorepeat_core.sv =====
// Each result is registered in the output buffer before o_rsp. Throughput: one
// request per cycle unless the buffer is full; the state update is a single
// registered pass. A two-entry result buffer keeps i_req ready while one result
// waits downstream. Reset (synchronous, active low) clears the key state and the
// beep counter and loads the default tick settings; no clearing pass follows.
module key_debounce_autorepeat_core #(
    parameter int COUNT_BITS = kda_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [kda_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [kda_pkg::CFG_BITS-1:0]    i_cfg_data,
    kda_req_if.sink                         i_req,
    kda_rsp_if.source                       o_rsp
);

    kda_pkg::t_cfg     r_cfg;
    kda_pkg::t_request req;
    kda_pkg::t_result  res, out_res;
    logic              space;
    logic              accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks     <= kda_pkg::DEF_DEBOUNCE;
            r_cfg.long_press_ticks   <= kda_pkg::DEF_LONG_PRESS;
            r_cfg.slow_repeat_ticks  <= kda_pkg::DEF_SLOW_REPEAT;
            r_cfg.slow4_delay_ticks  <= kda_pkg::DEF_SLOW4_DELAY;
            r_cfg.slow4_repeat_ticks <= kda_pkg::DEF_SLOW4_REPEAT;
            r_cfg.fast_start_ticks   <= kda_pkg::DEF_FAST_START;
            r_cfg.fast_repeat_ticks  <= kda_pkg::DEF_FAST_REPEAT;
            r_cfg.beep_ticks         <= kda_pkg::DEF_BEEP;
        end else if (i_cfg_we) begin
            unique case (kda_pkg::t_reg_idx'(i_cfg_idx))
                kda_pkg::REG_DEBOUNCE:     r_cfg.debounce_ticks     <= i_cfg_data;
                kda_pkg::REG_LONG_PRESS:   r_cfg.long_press_ticks   <= i_cfg_data;
                kda_pkg::REG_SLOW_REPEAT:  r_cfg.slow_repeat_ticks  <= i_cfg_data;
                kda_pkg::REG_SLOW4_DELAY:  r_cfg.slow4_delay_ticks  <= i_cfg_data;
                kda_pkg::REG_SLOW4_REPEAT: r_cfg.slow4_repeat_ticks <= i_cfg_data;
                kda_pkg::REG_FAST_START:   r_cfg.fast_start_ticks   <= i_cfg_data;
                kda_pkg::REG_FAST_REPEAT:  r_cfg.fast_repeat_ticks  <= i_cfg_data;
                kda_pkg::REG_BEEP: begin
                    r_cfg.beep_ticks <= i_cfg_data[kda_pkg::BEEP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign req.key_down        = i_req.key_down;
    assign req.key_index       = i_req.key_index;
    assign req.key_flags       = i_req.key_flags;
    assign req.key_code        = i_req.key_code;
    assign req.key_hold_code   = i_req.key_hold_code;
    assign req.hold_query_mask = i_req.hold_query_mask;

    assign i_req.ready = space;
    assign accept      = i_req.valid && space;

    kda_step #(
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (req),
        .i_cfg    (r_cfg),
        .o_res    (res)
    );

    kda_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (res),
        .o_space     (space),
        .o_valid     (o_rsp.valid),
        .i_pop_ready (o_rsp.ready),
        .o_data      (out_res)
    );

    assign o_rsp.key_valid  = out_res.key_valid;
    assign o_rsp.key_out    = out_res.key_out;
    assign o_rsp.enc_valid  = out_res.enc_valid;
    assign o_rsp.enc_code   = out_res.enc_code;
    assign o_rsp.enc_press  = out_res.enc_press;
    assign o_rsp.beep_on    = out_res.beep_on;
    assign o_rsp.hold_match = out_res.hold_match;

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kda_pkg::*;

    localparam int CNT_BITS = COUNT_BITS_DEF;
    localparam int SPAN_CAP = 150;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    t_reg_idx            cfg_idx;
    logic [CFG_BITS-1:0] cfg_data;

    kda_req_if req_ch ();
    kda_rsp_if rsp_ch ();

    key_debounce_autorepeat_core #(
        .COUNT_BITS(CNT_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    t_cfg settings = '{DEF_DEBOUNCE, DEF_LONG_PRESS, DEF_SLOW_REPEAT, DEF_SLOW4_DELAY,
                       DEF_SLOW4_REPEAT, DEF_FAST_START, DEF_FAST_REPEAT, DEF_BEEP};

    logic [CNT_BITS-1:0] press_cnt      = '0;
    logic [CNT_BITS-1:0] release_cnt    = '0;
    logic [5:0]          held_key       = '0;
    logic [7:0]          held_flags     = '0;
    logic [7:0]          held_code      = '0;
    logic [7:0]          held_hold_code = '0;
    logic [7:0]          beep_cnt       = '0;

    t_result  tick_results_due[$];
    t_request seen_req;
    t_result  got_result;
    t_result  want_result;
    int       errors        = 0;
    int       ticks_sent    = 0;
    bit       send_stall_on = 1'b1;
    bit       rsp_stall_on  = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    function automatic logic repeat_due(input logic [CFG_BITS-1:0] first,
                                        input logic [CFG_BITS-1:0] gap);
        press_cnt = press_cnt + 1'b1;
        if (32'(press_cnt) == 32'(first) + 32'(gap)) begin
            press_cnt = CNT_BITS'(first);
            return 1'b1;
        end
        return 32'(press_cnt) == 32'(first);
    endfunction

    function automatic t_result debounce_step(input t_request r);
        t_result res;
        logic    stable_n;
        logic    fresh;
        res      = '0;
        stable_n = 32'(press_cnt) < 32'(settings.debounce_ticks) + 1;
        if (r.key_down) begin
            if (!stable_n && held_key != r.key_index) fresh = 1'b1;
            else if (release_cnt != 0 && !stable_n) fresh = 1'b0;
            else if (press_cnt == 0) fresh = 1'b1;
            else fresh = stable_n && held_key != r.key_index;
            if (fresh) begin
                held_key       = r.key_index;
                held_flags     = r.key_flags;
                held_code      = r.key_code;
                held_hold_code = r.key_hold_code;
                press_cnt      = CNT_BITS'(1);
                release_cnt    = '0;
            end else begin
                release_cnt = CNT_BITS'(settings.debounce_ticks);
                if (held_flags[FLAG_SLOW]) begin
                    if (repeat_due(settings.long_press_ticks, settings.slow_repeat_ticks)) begin
                        res.key_valid = 1'b1;
                        res.key_out   = held_code;
                        release_cnt   = '0;
                    end
                end else if (held_flags[FLAG_SLOW4]) begin
                    if (repeat_due(settings.slow4_delay_ticks, settings.slow4_repeat_ticks)) begin
                        res.key_valid = 1'b1;
                        res.key_out   = held_code;
                        release_cnt   = '0;
                    end
                end else if (held_flags[FLAG_FAST]) begin
                    press_cnt = press_cnt + 1'b1;
                    if (32'(press_cnt) == 32'(settings.fast_start_ticks)) begin
                        press_cnt = CNT_BITS'(settings.fast_start_ticks)
                                  - CNT_BITS'(settings.fast_repeat_ticks);
                        res.enc_valid = 1'b1;
                        res.enc_code  = held_code;
                        res.enc_press = 1'b1;
                    end
                end else if (32'(press_cnt) < 32'(settings.long_press_ticks)) begin
                    press_cnt = press_cnt + 1'b1;
                    if (32'(press_cnt) == 32'(settings.long_press_ticks)) begin
                        res.key_valid = 1'b1;
                        res.key_out   = held_hold_code;
                    end
                end
            end
        end else if (release_cnt != 0) begin
            if (stable_n) begin
                press_cnt   = '0;
                release_cnt = '0;
            end else begin
                release_cnt = release_cnt - 1'b1;
                if (release_cnt == 0) begin
                    if (held_flags[FLAG_FAST]) begin
                        res.enc_valid = 1'b1;
                        res.enc_code  = held_code;
                    end else if (32'(press_cnt) < 32'(settings.long_press_ticks)) begin
                        res.key_valid = 1'b1;
                        res.key_out   = held_code;
                    end
                    press_cnt = '0;
                end
            end
        end
        if (res.key_valid) beep_cnt = settings.beep_ticks;
        else if (beep_cnt != 0) beep_cnt = beep_cnt - 1'b1;
        res.beep_on    = beep_cnt != 0;
        res.hold_match = press_cnt != 0 && (held_flags & r.hold_query_mask) != 0;
        return res;
    endfunction

    function automatic void take_setting(input t_reg_idx idx, input logic [CFG_BITS-1:0] data);
        case (idx)
            REG_DEBOUNCE:     settings.debounce_ticks     = data;
            REG_LONG_PRESS:   settings.long_press_ticks   = data;
            REG_SLOW_REPEAT:  settings.slow_repeat_ticks  = data;
            REG_SLOW4_DELAY:  settings.slow4_delay_ticks  = data;
            REG_SLOW4_REPEAT: settings.slow4_repeat_ticks = data;
            REG_FAST_START:   settings.fast_start_ticks   = data;
            REG_FAST_REPEAT:  settings.fast_repeat_ticks  = data;
            REG_BEEP:         settings.beep_ticks         = data[BEEP_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_we) take_setting(cfg_idx, cfg_data);
            if (req_ch.valid && req_ch.ready) begin
                seen_req = {req_ch.key_down, req_ch.key_index, req_ch.key_flags,
                            req_ch.key_code, req_ch.key_hold_code, req_ch.hold_query_mask};
                tick_results_due.push_back(debounce_step(seen_req));
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                got_result = {rsp_ch.key_valid, rsp_ch.key_out, rsp_ch.enc_valid,
                              rsp_ch.enc_code, rsp_ch.enc_press, rsp_ch.beep_on,
                              rsp_ch.hold_match};
                if (tick_results_due.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with no request pending, expected none, actual 0x%0h",
                             $time, got_result);
                end else begin
                    want_result = tick_results_due.pop_front();
                    check_field("key_valid", want_result.key_valid, got_result.key_valid);
                    check_field("key_out", want_result.key_out, got_result.key_out);
                    check_field("enc_valid", want_result.enc_valid, got_result.enc_valid);
                    check_field("enc_code", want_result.enc_code, got_result.enc_code);
                    check_field("enc_press", want_result.enc_press, got_result.enc_press);
                    check_field("beep_on", want_result.beep_on, got_result.beep_on);
                    check_field("hold_match", want_result.hold_match, got_result.hold_match);
                end
            end
        end
    end

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 2);
        if (pick < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int hold_off;
        hold_off     = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off == 0 && rsp_stall_on && $urandom_range(0, 99) < 25) begin
                hold_off = gap_len();
            end
            if (hold_off > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_off--;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_tick(input t_request r);
        int gap;
        gap = (send_stall_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        {req_ch.key_down, req_ch.key_index, req_ch.key_flags, req_ch.key_code,
         req_ch.key_hold_code, req_ch.hold_query_mask} <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    task automatic press_key(input logic [5:0] idx, input logic [7:0] flags,
                             input logic [7:0] code, input logic [7:0] hold_code,
                             input int n, input bit scramble);
        t_request r;
        for (int i = 0; i < n; i++) begin
            r.key_down        = 1'b1;
            r.key_index       = idx;
            r.key_flags       = flags;
            r.key_code        = code;
            r.key_hold_code   = hold_code;
            r.hold_query_mask = 8'($urandom);
            // later ticks may carry other attributes; the latched ones must win
            if (scramble && i > 0 && $urandom_range(0, 1) == 1) begin
                r.key_flags     = 8'($urandom);
                r.key_code      = 8'($urandom);
                r.key_hold_code = 8'($urandom);
            end
            send_tick(r);
        end
    endtask

    task automatic release_key(input int n);
        t_request r;
        repeat (n) begin
            r          = t_request'({$urandom, $urandom});
            r.key_down = 1'b0;
            send_tick(r);
        end
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (tick_results_due.size() != 0);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_BITS-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(input t_cfg c);
        drain();
        repeat (3) @(negedge i_clk);
        write_reg(REG_DEBOUNCE, c.debounce_ticks);
        write_reg(REG_LONG_PRESS, c.long_press_ticks);
        write_reg(REG_SLOW_REPEAT, c.slow_repeat_ticks);
        write_reg(REG_SLOW4_DELAY, c.slow4_delay_ticks);
        write_reg(REG_SLOW4_REPEAT, c.slow4_repeat_ticks);
        write_reg(REG_FAST_START, c.fast_start_ticks);
        write_reg(REG_FAST_REPEAT, c.fast_repeat_ticks);
        write_reg(REG_BEEP, CFG_BITS'(c.beep_ticks));
        cfg_we <= 1'b0;
    endtask

    function automatic t_cfg make_settings(input int deb, input int long_press,
                                           input int slow_rep, input int slow4_delay,
                                           input int slow4_rep, input int fast_start,
                                           input int fast_rep, input int beep);
        t_cfg c;
        c.debounce_ticks     = CFG_BITS'(deb);
        c.long_press_ticks   = CFG_BITS'(long_press);
        c.slow_repeat_ticks  = CFG_BITS'(slow_rep);
        c.slow4_delay_ticks  = CFG_BITS'(slow4_delay);
        c.slow4_repeat_ticks = CFG_BITS'(slow4_rep);
        c.fast_start_ticks   = CFG_BITS'(fast_start);
        c.fast_repeat_ticks  = CFG_BITS'(fast_rep);
        c.beep_ticks         = BEEP_BITS'(beep);
        return c;
    endfunction

    function automatic logic [7:0] random_flags();
        logic [7:0] hi;
        int         pick;
        hi   = 8'($urandom) & 8'hF8;
        pick = $urandom_range(0, 99);
        if (pick < 25) return hi;
        if (pick < 45) return hi | 8'($urandom_range(0, 7)) | (8'd1 << FLAG_SLOW);
        if (pick < 65) return hi | (8'd1 << FLAG_SLOW4) | (8'($urandom_range(0, 1)) << FLAG_FAST);
        if (pick < 85) return hi | (8'd1 << FLAG_FAST);
        return 8'($urandom);
    endfunction

    task automatic run_key_traffic(input int n);
        int stop_at;
        int kind;
        int hold_span;
        int settle_span;
        stop_at   = ticks_sent + n;
        hold_span = 32'(settings.long_press_ticks) + 2 * 32'(settings.slow_repeat_ticks) + 4;
        if (hold_span > SPAN_CAP) hold_span = SPAN_CAP;
        settle_span = (settings.debounce_ticks > 30) ? 33 : 32'(settings.debounce_ticks) + 3;
        while (ticks_sent < stop_at) begin
            kind          = $urandom_range(0, 99);
            send_stall_on = $urandom_range(0, 7) != 0;
            rsp_stall_on  = $urandom_range(0, 7) != 0;
            if (kind < 75) begin
                press_key(6'($urandom), random_flags(), 8'($urandom), 8'($urandom),
                          $urandom_range(1, hold_span), $urandom_range(0, 3) == 0);
                release_key($urandom_range(0, settle_span));
            end else if (kind < 90) begin
                // bounce between keys
                repeat ($urandom_range(2, 5)) begin
                    press_key(6'($urandom), random_flags(), 8'($urandom), 8'($urandom),
                              $urandom_range(1, 3), 1'b0);
                    release_key($urandom_range(0, 2));
                end
            end else if (kind < 98) begin
                repeat ($urandom_range(1, 8)) begin
                    send_tick(t_request'({$urandom, $urandom}));
                end
            end else begin
                drain();
            end
        end
    endtask

    task automatic test_short_and_long_press();
        apply_settings(make_settings(1, 4, 0, 2, 1, 2, 3, 0));
        press_key(6'd63, 8'hF8, 8'hFF, 8'h00, 2, 1'b0);
        release_key(1);
        press_key(6'd0, 8'h00, 8'h00, 8'hFF, 5, 1'b0);
        release_key(1);
    endtask

    task automatic test_repeat_keys();
        press_key(6'd21, 8'h01, 8'hA5, 8'h5A, 5, 1'b0);
        release_key(1);
        // same key again after the release starts a new press
        press_key(6'd21, 8'h01, 8'h11, 8'h22, 2, 1'b0);
        press_key(6'd42, 8'h02, 8'h3C, 8'hC3, 4, 1'b1);
        release_key(1);
    endtask

    task automatic test_fast_encoder();
        // repeat above start: reload wraps the counter
        press_key(6'd7, 8'h04, 8'h77, 8'h88, 5, 1'b0);
        release_key(2);
    endtask

    task automatic test_config_extremes();
        apply_settings(make_settings(32767, 32767, 32767, 32767, 32767, 32767, 32767, 255));
        run_key_traffic(60);
        apply_settings(make_settings(1, 2, 1, 2, 1, 2, 1, 1));
        run_key_traffic(150);
    endtask

    task automatic test_random_settings();
        repeat (5) begin
            apply_settings(make_settings($urandom_range(1, 4), $urandom_range(3, 24),
                                         $urandom_range(0, 6), $urandom_range(2, 10),
                                         $urandom_range(0, 4), $urandom_range(2, 10),
                                         $urandom_range(1, 12), $urandom_range(0, 8)));
            run_key_traffic(190);
        end
    endtask

    task automatic test_default_settings();
        apply_settings(make_settings(DEF_DEBOUNCE, DEF_LONG_PRESS, DEF_SLOW_REPEAT,
                                     DEF_SLOW4_DELAY, DEF_SLOW4_REPEAT, DEF_FAST_START,
                                     DEF_FAST_REPEAT, DEF_BEEP));
        run_key_traffic(150);
    endtask

    initial begin
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_idx                = REG_DEBOUNCE;
        cfg_data               = '0;
        req_ch.valid           = 1'b0;
        req_ch.key_down        = 1'b0;
        req_ch.key_index       = '0;
        req_ch.key_flags       = '0;
        req_ch.key_code        = '0;
        req_ch.key_hold_code   = '0;
        req_ch.hold_query_mask = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_short_and_long_press();
        test_repeat_keys();
        test_fast_encoder();
        test_config_extremes();
        test_random_settings();
        test_default_settings();

        drain();
        repeat (4) @(negedge i_clk);
        if (errors == 0 && tick_results_due.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
